// ----- hdl/whp_pkg.sv -----
package whp_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int DIVISOR_W   = 18;
  localparam int DIVIDEND_W  = 32;

  localparam logic [31:0] TAG_RIFF = 32'h52494646;
  localparam logic [31:0] TAG_WAVE = 32'h57415645;
  localparam logic [31:0] TAG_FMT  = 32'h666d7420;
  localparam logic [31:0] TAG_DATA = 32'h64617461;
  localparam logic [15:0] FMT_PCM  = 16'h0001;
  localparam logic [15:0] FMT_EXT  = 16'hfffe;
  localparam logic [31:0] GUID_W0  = 32'h00000001;
  localparam logic [31:0] GUID_W1  = 32'h00100000;
  localparam logic [31:0] GUID_W2  = 32'haa000080;
  localparam logic [31:0] GUID_W3  = 32'h719b3800;
  localparam logic [31:0] MASK_MONO   = 32'h00000004;
  localparam logic [31:0] MASK_STEREO = 32'h00000003;
  localparam logic [15:0] EXT_SIZE = 16'd22;

  localparam logic [1:0] RK_SAMPLE = 2'd0;
  localparam logic [1:0] RK_HEADER = 2'd1;
  localparam logic [1:0] RK_ERROR  = 2'd2;

  localparam logic [3:0] ERR_NOT_RIFF  = 4'd0;
  localparam logic [3:0] ERR_SIZE      = 4'd1;
  localparam logic [3:0] ERR_NOT_WAVE  = 4'd2;
  localparam logic [3:0] ERR_TAG       = 4'd3;
  localparam logic [3:0] ERR_DEPTH     = 4'd4;
  localparam logic [3:0] ERR_ALIGN     = 4'd5;
  localparam logic [3:0] ERR_EXTSIZE   = 4'd6;
  localparam logic [3:0] ERR_GUID      = 4'd7;
  localparam logic [3:0] ERR_CHANNELS  = 4'd8;
  localparam logic [3:0] ERR_SAMPSIZE  = 4'd9;
  localparam logic [3:0] ERR_TRUNCATED = 4'd10;

  typedef enum logic [4:0] {
    PH_RIFF, PH_SIZE, PH_WAVE, PH_ID1, PH_LEN1, PH_SKIP1, PH_FMTLEN, PH_FTAG,
    PH_CHAN, PH_RATE, PH_AVG, PH_ALIGN, PH_BITS, PH_EXTSZ, PH_VALID, PH_MASK,
    PH_G0, PH_G1, PH_G2, PH_G3, PH_FSKIP, PH_ID2, PH_LEN2, PH_SKIP2, PH_DLEN,
    PH_DATA, PH_DONE, PH_ERR, PH_DIV
  } phase_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] in_byte;
  } req_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [31:0] sample;
    logic [15:0] channel_index;
    logic        last_sample;
    logic [15:0] channel_count;
    logic [31:0] sample_rate;
    logic [5:0]  valid_bits;
    logic [4:0]  drop_bits;
    logic [31:0] channel_mask;
    logic [3:0]  error_code;
  } res_t;

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVISOR_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic                 busy;
    logic [DIVISOR_W-1:0] rem;
  } div_rsp_t;

  function automatic logic [2:0] field_len(input phase_t ph);
    logic [2:0] n;
    unique case (ph)
      PH_FTAG, PH_CHAN, PH_ALIGN, PH_BITS, PH_EXTSZ, PH_VALID: n = 3'd2;
      PH_SKIP1, PH_FSKIP, PH_SKIP2, PH_DATA, PH_DONE, PH_ERR, PH_DIV: n = 3'd1;
      default: n = 3'd4;
    endcase
    return n;
  endfunction

endpackage

// ----- hdl/wav_header_parse_pcm_unpack.sv -----
// Channel | Direction | Handshake               | Payload
// src     | in        | src_valid / src_stall   | whp_pkg::req_t (kind, in_byte)
// dst     | out       | dst_valid / dst_stall   | whp_pkg::res_t (result fields)
//
// One file byte per cycle when neither side stalls and the divider is idle;
// bytes land in a small request queue, the parser drains one request per cycle
// into an output register. A one-bit-per-cycle divider trims the data-chunk
// length to whole frames before the header result goes out.
// rst is synchronous, active high, and returns the parser to the RIFF tag.
// A stalled output holds the parser; the queue keeps taking bytes until full.
module wav_header_parse_pcm_unpack #(
  parameter int QueueDepth = whp_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          src_valid,
  output logic          src_stall,
  input  whp_pkg::req_t src_req,
  output logic          dst_valid,
  input  logic          dst_stall,
  output whp_pkg::res_t dst_res
);
  logic              head_valid, pop;
  whp_pkg::req_t     head;
  whp_pkg::div_req_t div_req;
  whp_pkg::div_rsp_t div_rsp;

  // front: accept bytes into the request queue
  whp_front #(.Depth(QueueDepth)) u_front (
    .clk, .rst, .src_valid, .src_stall, .src_req,
    .head_valid, .head, .pop
  );

  // divider for the data length
  whp_div u_div (.clk, .rst, .req(div_req), .rsp(div_rsp));

  // back: chunk parser, sample unpack, output register
  whp_back u_back (
    .clk, .rst, .head_valid, .head, .pop, .div_req, .div_rsp,
    .dst_valid, .dst_stall, .dst_res
  );
endmodule

// ----- hdl/whp_front.sv -----
module whp_front #(
  parameter int Depth = whp_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          src_valid,
  output logic          src_stall,
  input  whp_pkg::req_t src_req,
  output logic          head_valid,
  output whp_pkg::req_t head,
  input  logic          pop
);
  localparam int PW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);

  whp_pkg::req_t mem [Depth];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic push, do_pop;

  assign src_stall  = (count == CW'(Depth));
  assign push       = src_valid && !src_stall;
  assign head_valid = (count != '0);
  assign do_pop     = pop && head_valid;
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= src_req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end
endmodule

// ----- hdl/whp_div.sv -----
module whp_div (
  input  logic              clk,
  input  logic              rst,
  input  whp_pkg::div_req_t req,
  output whp_pkg::div_rsp_t rsp
);
  localparam int NW = whp_pkg::DIVIDEND_W;
  localparam int DW = whp_pkg::DIVISOR_W;

  logic                  busy;
  logic [$clog2(NW)-1:0] cnt;
  logic [NW-1:0]         dvd;
  logic [DW-1:0]         dvs;
  logic [DW-1:0]         rem;
  logic [DW:0]           trial;

  assign trial    = {rem, dvd[NW-1]};
  assign rsp.busy = busy;
  assign rsp.rem  = rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      rem  <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      cnt  <= '0;
      rem  <= '0;
    end else if (busy) begin
      rem  <= (trial >= {1'b0, dvs}) ? DW'(trial - {1'b0, dvs}) : trial[DW-1:0];
      cnt  <= cnt + 1'b1;
      if (cnt == $clog2(NW)'(NW - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd <= req.dividend;
      dvs <= req.divisor;
    end else if (busy) begin
      dvd <= {dvd[NW-2:0], 1'b0};
    end
  end
endmodule

// ----- hdl/whp_back.sv -----
module whp_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              head_valid,
  input  whp_pkg::req_t     head,
  output logic              pop,
  output whp_pkg::div_req_t div_req,
  input  whp_pkg::div_rsp_t div_rsp,
  output logic              dst_valid,
  input  logic              dst_stall,
  output whp_pkg::res_t     dst_res
);
  whp_pkg::phase_t phase, phase_next;
  logic [1:0]  bif, bif_next;
  logic [31:0] asm_word, asm_word_next;
  logic [31:0] skip, skip_next;
  logic [15:0] ftag, ftag_next;
  logic [15:0] chans, chans_next;
  logic [31:0] rate, rate_next;
  logic [15:0] balign, balign_next;
  logic [15:0] cbits, cbits_next;
  logic [4:0]  wasted, wasted_next;
  logic [31:0] mask, mask_next;
  logic [31:0] dleft, dleft_next;
  logic [15:0] chcnt, chcnt_next;
  logic [5:0]  fused, fused_next;
  logic        gbad, gbad_next;

  whp_pkg::res_t res;
  logic        res_fire, out_free, take;
  logic [7:0]  b;
  logic [31:0] word, w;
  logic [2:0]  len, ss;
  logic [12:0] ss_wide;
  logic [31:0] prod;
  logic [15:0] w16;
  logic [31:0] left;
  logic signed [32:0] s, sum, q;
  logic [32:0] rmask;
  logic [16:0] chinc;

  assign out_free = !dst_valid || !dst_stall;
  assign take     = head_valid && out_free && (phase != whp_pkg::PH_DIV);
  assign pop      = take;
  assign b        = head.in_byte;
  assign ss_wide  = cbits[15:3];
  assign ss       = cbits[5:3];
  assign prod     = w[15:0] * chans;
  assign w16      = w[15:0];
  assign chinc    = {1'b0, chcnt} + 17'd1;

  always_comb begin
    len  = whp_pkg::field_len(phase);
    word = asm_word | (32'(b) << {bif, 3'b000});
    if (phase == whp_pkg::PH_RIFF || phase == whp_pkg::PH_SIZE ||
        phase == whp_pkg::PH_WAVE || phase == whp_pkg::PH_ID1 ||
        phase == whp_pkg::PH_ID2) begin
      word = {asm_word[23:0], b};
    end
    w = word;
  end

  always_comb begin
    unique case (ss)
      3'd1:    s = $signed({25'b0, word[7:0]}) - 33'sd128;
      3'd2:    s = {{17{word[15]}}, word[15:0]};
      3'd3:    s = {{9{word[23]}}, word[23:0]};
      default: s = {word[31], word};
    endcase
    rmask = ~({33{1'b1}} << wasted);
    sum   = s + (s[32] ? $signed(rmask) : 33'sd0);
    q     = sum >>> wasted;
  end

  always_comb begin
    phase_next = phase;   bif_next = bif;       asm_word_next = asm_word;
    skip_next = skip;     ftag_next = ftag;     chans_next = chans;
    rate_next = rate;     balign_next = balign; cbits_next = cbits;
    wasted_next = wasted; mask_next = mask;     dleft_next = dleft;
    chcnt_next = chcnt;   fused_next = fused;   gbad_next = gbad;
    res = '0;
    res_fire = 1'b0;
    div_req = '0;
    left = '0;

    if (phase == whp_pkg::PH_DIV) begin
      if (!div_rsp.busy && out_free) begin
        dleft_next = dleft - 32'(div_rsp.rem);
        res_fire = 1'b1;
        res.result_kind   = whp_pkg::RK_HEADER;
        res.channel_count = chans;
        res.sample_rate   = rate;
        res.valid_bits    = 6'(cbits - 16'(wasted));
        res.drop_bits     = wasted;
        res.channel_mask  = mask;
        phase_next = (dleft_next == '0) ? whp_pkg::PH_DONE : whp_pkg::PH_DATA;
      end
    end else if (take && phase != whp_pkg::PH_DONE && phase != whp_pkg::PH_ERR) begin
      if (head.kind) begin
        res_fire = 1'b1;
        res.result_kind = whp_pkg::RK_ERROR;
        res.error_code  = whp_pkg::ERR_TRUNCATED;
        phase_next = whp_pkg::PH_ERR;
      end else if (phase == whp_pkg::PH_SKIP1 || phase == whp_pkg::PH_SKIP2 ||
                   phase == whp_pkg::PH_FSKIP) begin
        skip_next = skip - 32'd1;
        if (skip == 32'd1) begin
          phase_next = (phase == whp_pkg::PH_SKIP1) ? whp_pkg::PH_ID1 : whp_pkg::PH_ID2;
        end
      end else if (phase == whp_pkg::PH_DATA) begin
        dleft_next = dleft - 32'd1;
        if ({1'b0, bif} + 3'd1 < ss) begin
          bif_next = bif + 2'd1;
          asm_word_next = word;
        end else begin
          res_fire = 1'b1;
          res.result_kind   = whp_pkg::RK_SAMPLE;
          res.sample        = q[31:0];
          res.channel_index = chcnt;
          res.last_sample   = (dleft == 32'd1);
          chcnt_next = (chinc >= {1'b0, chans}) ? '0 : chinc[15:0];
          bif_next = '0;
          asm_word_next = '0;
          if (dleft == 32'd1) begin
            phase_next = whp_pkg::PH_DONE;
          end
        end
      end else begin
        if (phase >= whp_pkg::PH_FTAG && phase <= whp_pkg::PH_G3) begin
          fused_next = fused + 6'd1;
        end
        left = (skip > 32'(fused_next)) ? skip - 32'(fused_next) : '0;
        if ({1'b0, bif} + 3'd1 < len) begin
          bif_next = bif + 2'd1;
          asm_word_next = word;
        end else begin
          bif_next = '0;
          asm_word_next = '0;
          res.result_kind = whp_pkg::RK_ERROR;
          unique case (phase)
            whp_pkg::PH_RIFF: begin
              if (w != whp_pkg::TAG_RIFF) begin
                res_fire = 1'b1; res.error_code = whp_pkg::ERR_NOT_RIFF;
              end else phase_next = whp_pkg::PH_SIZE;
            end
            whp_pkg::PH_SIZE: begin
              if (w == 32'hffffffff) begin
                res_fire = 1'b1; res.error_code = whp_pkg::ERR_SIZE;
              end else phase_next = whp_pkg::PH_WAVE;
            end
            whp_pkg::PH_WAVE: begin
              if (w != whp_pkg::TAG_WAVE) begin
                res_fire = 1'b1; res.error_code = whp_pkg::ERR_NOT_WAVE;
              end else phase_next = whp_pkg::PH_ID1;
            end
            whp_pkg::PH_ID1: begin
              phase_next = (w == whp_pkg::TAG_FMT) ? whp_pkg::PH_FMTLEN : whp_pkg::PH_LEN1;
            end
            whp_pkg::PH_LEN1: begin
              skip_next = w;
              phase_next = (w == '0) ? whp_pkg::PH_ID1 : whp_pkg::PH_SKIP1;
            end
            whp_pkg::PH_FMTLEN: begin
              skip_next = w;
              fused_next = '0;
              phase_next = whp_pkg::PH_FTAG;
            end
            whp_pkg::PH_FTAG: begin
              ftag_next = w16;
              if (w16 != whp_pkg::FMT_PCM && w16 != whp_pkg::FMT_EXT) begin
                res_fire = 1'b1; res.error_code = whp_pkg::ERR_TAG;
              end else phase_next = whp_pkg::PH_CHAN;
            end
            whp_pkg::PH_CHAN: begin
              chans_next = w16;
              phase_next = whp_pkg::PH_RATE;
            end
            whp_pkg::PH_RATE: begin
              rate_next = w;
              phase_next = whp_pkg::PH_AVG;
            end
            whp_pkg::PH_AVG: phase_next = whp_pkg::PH_ALIGN;
            whp_pkg::PH_ALIGN: begin
              balign_next = w16;
              phase_next = whp_pkg::PH_BITS;
            end
            whp_pkg::PH_BITS: begin
              cbits_next = w16;
              wasted_next = '0;
              if (w16[2:0] != 3'd0) begin
                res_fire = 1'b1; res.error_code = whp_pkg::ERR_DEPTH;
              end else if (prod[31:3] != {13'b0, balign}) begin
                res_fire = 1'b1; res.error_code = whp_pkg::ERR_ALIGN;
              end else if (ftag == whp_pkg::FMT_EXT) begin
                phase_next = whp_pkg::PH_EXTSZ;
              end else if (chans != 16'd1 && chans != 16'd2) begin
                res_fire = 1'b1; res.error_code = whp_pkg::ERR_CHANNELS;
              end else begin
                mask_next = (chans == 16'd1) ? whp_pkg::MASK_MONO : whp_pkg::MASK_STEREO;
                skip_next = left;
                phase_next = (left == '0) ? whp_pkg::PH_ID2 : whp_pkg::PH_FSKIP;
              end
            end
            whp_pkg::PH_EXTSZ: begin
              if (w16 != whp_pkg::EXT_SIZE) begin
                res_fire = 1'b1; res.error_code = whp_pkg::ERR_EXTSIZE;
              end else phase_next = whp_pkg::PH_VALID;
            end
            whp_pkg::PH_VALID: begin
              if (w16 == '0 || w16 > cbits) begin
                res_fire = 1'b1; res.error_code = whp_pkg::ERR_DEPTH;
              end else begin
                wasted_next = 5'(cbits - w16);
                phase_next = whp_pkg::PH_MASK;
              end
            end
            whp_pkg::PH_MASK: begin
              mask_next = w;
              gbad_next = 1'b0;
              phase_next = whp_pkg::PH_G0;
            end
            whp_pkg::PH_G0: begin
              gbad_next = gbad || (w != whp_pkg::GUID_W0);
              phase_next = whp_pkg::PH_G1;
            end
            whp_pkg::PH_G1: begin
              gbad_next = gbad || (w != whp_pkg::GUID_W1);
              phase_next = whp_pkg::PH_G2;
            end
            whp_pkg::PH_G2: begin
              gbad_next = gbad || (w != whp_pkg::GUID_W2);
              phase_next = whp_pkg::PH_G3;
            end
            whp_pkg::PH_G3: begin
              if (gbad || w != whp_pkg::GUID_W3) begin
                res_fire = 1'b1; res.error_code = whp_pkg::ERR_GUID;
              end else begin
                skip_next = left;
                phase_next = (left == '0) ? whp_pkg::PH_ID2 : whp_pkg::PH_FSKIP;
              end
            end
            whp_pkg::PH_ID2: begin
              phase_next = (w == whp_pkg::TAG_DATA) ? whp_pkg::PH_DLEN : whp_pkg::PH_LEN2;
            end
            whp_pkg::PH_LEN2: begin
              skip_next = w;
              phase_next = (w == '0) ? whp_pkg::PH_ID2 : whp_pkg::PH_SKIP2;
            end
            whp_pkg::PH_DLEN: begin
              if (ss_wide < 13'd1 || ss_wide > 13'd4) begin
                res_fire = 1'b1; res.error_code = whp_pkg::ERR_SAMPSIZE;
              end else if (chans == '0) begin
                res_fire = 1'b1; res.error_code = whp_pkg::ERR_CHANNELS;
              end else begin
                div_req.start    = 1'b1;
                div_req.dividend = w;
                div_req.divisor  = whp_pkg::DIVISOR_W'(ss) * whp_pkg::DIVISOR_W'(chans);
                dleft_next = w;
                chcnt_next = '0;
                phase_next = whp_pkg::PH_DIV;
              end
            end
            default: phase_next = phase;
          endcase
          if (res_fire) begin
            phase_next = whp_pkg::PH_ERR;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= whp_pkg::PH_RIFF;
      bif <= '0;    asm_word <= '0; skip <= '0;   ftag <= '0;
      chans <= '0;  rate <= '0;     balign <= '0; cbits <= '0;
      wasted <= '0; mask <= '0;     dleft <= '0;  chcnt <= '0;
      fused <= '0;  gbad <= 1'b0;
      dst_valid <= 1'b0;
    end else begin
      phase <= phase_next;
      bif <= bif_next;       asm_word <= asm_word_next; skip <= skip_next;
      ftag <= ftag_next;     chans <= chans_next;       rate <= rate_next;
      balign <= balign_next; cbits <= cbits_next;       wasted <= wasted_next;
      mask <= mask_next;     dleft <= dleft_next;       chcnt <= chcnt_next;
      fused <= fused_next;   gbad <= gbad_next;
      if (res_fire) begin
        dst_valid <= 1'b1;
      end else if (!dst_stall) begin
        dst_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_fire) begin
      dst_res <= res;
    end
  end
endmodule
